@@ rtl/ialu_pkg.sv @@
// ----------------------------------------------------------------------------
// ialu_pkg: shared types and constants for the integer ALU with HI/LO unit
// Opcode encoding, transaction payload structs and sequencer state type.
// ----------------------------------------------------------------------------
package ialu_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 5;
	localparam logic [CNT_W-1:0] ITER_LAST = '1;

	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_ADDI  = 5'd1,
		OP_ADDIU = 5'd2,
		OP_ADDU  = 5'd3,
		OP_SUB   = 5'd4,
		OP_SUBU  = 5'd5,
		OP_DIV   = 5'd6,
		OP_DIVU  = 5'd7,
		OP_MULT  = 5'd8,
		OP_MULTU = 5'd9,
		OP_SLL   = 5'd10,
		OP_SLLV  = 5'd11,
		OP_SRA   = 5'd12,
		OP_SRAV  = 5'd13,
		OP_SRL   = 5'd14,
		OP_SRLV  = 5'd15,
		OP_AND   = 5'd16,
		OP_ANDI  = 5'd17,
		OP_NOR   = 5'd18,
		OP_OR    = 5'd19,
		OP_ORI   = 5'd20,
		OP_XOR   = 5'd21,
		OP_XORI  = 5'd22,
		OP_SLT   = 5'd23,
		OP_SLTI  = 5'd24,
		OP_SLTIU = 5'd25,
		OP_SLTU  = 5'd26
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_NEG_A,
		S_NEG_B,
		S_MUL,
		S_DIV,
		S_MUL_FIXA,
		S_MUL_FIXB,
		S_DIV_FIXQ,
		S_DIV_FIXR,
		S_MD_DONE
	} state_t;

	typedef struct packed {
		logic [4:0]        opcode;
		logic [DATA_W-1:0] rs_value;
		logic [DATA_W-1:0] rt_value;
		logic [15:0]       immediate;
		logic [4:0]        shift_amount;
	} alu_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic              result_write;
		logic              overflow;
		logic [DATA_W-1:0] hi_out;
		logic [DATA_W-1:0] lo_out;
	} alu_rsp_t;

endpackage

@@ rtl/integer_alu_with_hi_lo_muldiv_core.sv @@
// ----------------------------------------------------------------------------
// integer_alu_with_hi_lo_muldiv_core: 32-bit integer ALU with HI/LO mul/div
// Executes one integer instruction per transaction; multiply and divide run
// on a shared 33-bit adder under a small sequencer and update HI and LO.
// ----------------------------------------------------------------------------
// A request is taken only while the sequencer is idle and the block then
// holds stall high until its result is registered. Add, shift, logic and
// compare instructions finish in S_EXEC. MULT and MULTU pass S_MUL and sign
// fix-ups S_MUL_FIXA and S_MUL_FIXB; DIV and DIVU pass S_NEG_A, S_NEG_B,
// S_DIV and fix-ups S_DIV_FIXQ and S_DIV_FIXR. Both end in S_MD_DONE and use
// the single 33-bit adder for one shift-add or restore step per cycle over 32
// iterations. A divide by zero ends in S_EXEC and leaves HI and LO untouched.
// The response register lets a new request in while the last result waits.
module integer_alu_with_hi_lo_muldiv_core
	import ialu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  alu_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output alu_rsp_t rsp
);

	state_t             state_q, state_d;
	alu_req_t           op_q;
	logic [DATA_W-1:0]  acc_q, acc_d;
	logic [DATA_W-1:0]  quo_q, quo_d;
	logic [DATA_W-1:0]  opb_q, opb_d;
	logic               na_q, na_d, nb_q, nb_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [DATA_W-1:0]  hi_q, lo_q, hi_d, lo_d;
	logic               rsp_valid_q;
	alu_rsp_t           rsp_q, rsp_d;
	logic               rsp_load;
	logic               out_free;
	logic               req_accept;

	// Shared adder / subtractor
	logic [DATA_W:0]    add_x, add_y;
	logic               add_sub;
	logic [DATA_W+1:0]  add_sum;

	logic [DATA_W-1:0]  a, b, imm_s, imm_z;
	logic [4:0]         vsa;
	logic [DATA_W:0]    div_shift;
	logic [DATA_W-1:0]  res_c;
	logic               wr_c, ovf_c;
	logic               exec_done;

	assign a     = op_q.rs_value;
	assign b     = op_q.rt_value;
	assign imm_s = {{(DATA_W-16){op_q.immediate[15]}}, op_q.immediate};
	assign imm_z = {{(DATA_W-16){1'b0}}, op_q.immediate};
	assign vsa   = a[4:0];

	assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
		+ {{(DATA_W+1){1'b0}}, add_sub};

	assign div_shift = {acc_q, quo_q[DATA_W-1]};

	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign req_stall  = (state_q != S_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	// Combinational result of the simple instructions, and whether EXEC ends here
	always_comb begin
		res_c     = '0;
		wr_c      = 1'b1;
		ovf_c     = 1'b0;
		exec_done = 1'b1;
		case (op_q.opcode)
			OP_ADD: begin
				ovf_c = (a[DATA_W-1] ^ add_sum[DATA_W-1]) & (b[DATA_W-1] ^ add_sum[DATA_W-1]);
				res_c = ovf_c ? '0 : add_sum[DATA_W-1:0];
			end
			OP_ADDI: begin
				ovf_c = (a[DATA_W-1] ^ add_sum[DATA_W-1])
					& (imm_s[DATA_W-1] ^ add_sum[DATA_W-1]);
				res_c = ovf_c ? '0 : add_sum[DATA_W-1:0];
			end
			OP_SUB: begin
				ovf_c = (a[DATA_W-1] ^ b[DATA_W-1]) & (a[DATA_W-1] ^ add_sum[DATA_W-1]);
				res_c = ovf_c ? '0 : add_sum[DATA_W-1:0];
			end
			OP_ADDIU, OP_ADDU, OP_SUBU: res_c = add_sum[DATA_W-1:0];
			OP_DIV, OP_DIVU: begin
				wr_c      = 1'b0;
				exec_done = (b == '0);
			end
			OP_MULT, OP_MULTU: begin
				wr_c      = 1'b0;
				exec_done = 1'b0;
			end
			OP_SLL:   res_c = b << op_q.shift_amount;
			OP_SLLV:  res_c = b << vsa;
			OP_SRA:   res_c = DATA_W'($signed(b) >>> op_q.shift_amount);
			OP_SRAV:  res_c = DATA_W'($signed(b) >>> vsa);
			OP_SRL:   res_c = b >> op_q.shift_amount;
			OP_SRLV:  res_c = b >> vsa;
			OP_AND:   res_c = a & b;
			OP_ANDI:  res_c = a & imm_z;
			OP_NOR:   res_c = ~(a | b);
			OP_OR:    res_c = a | b;
			OP_ORI:   res_c = a | imm_z;
			OP_XOR:   res_c = a ^ b;
			OP_XORI:  res_c = a ^ imm_z;
			OP_SLT:   res_c = {{(DATA_W-1){1'b0}}, ($signed(a) < $signed(b))};
			OP_SLTI:  res_c = {{(DATA_W-1){1'b0}}, ($signed(a) < $signed(imm_s))};
			OP_SLTIU: res_c = {{(DATA_W-1){1'b0}}, (a < imm_s)};
			OP_SLTU:  res_c = {{(DATA_W-1){1'b0}}, (a < b)};
			default:  wr_c  = 1'b0;
		endcase
		if (ovf_c) begin
			wr_c = 1'b0;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (req_valid) state_d = S_EXEC;
			S_EXEC: begin
				if (op_q.opcode == OP_MULT || op_q.opcode == OP_MULTU) begin
					state_d = S_MUL;
				end else if (!exec_done) begin
					state_d = S_NEG_A;
				end else if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_NEG_A:    state_d = S_NEG_B;
			S_NEG_B:    state_d = S_DIV;
			S_MUL:      if (cnt_q == ITER_LAST) state_d = S_MUL_FIXA;
			S_DIV:      if (cnt_q == ITER_LAST) state_d = S_DIV_FIXQ;
			S_MUL_FIXA: state_d = S_MUL_FIXB;
			S_MUL_FIXB: state_d = S_MD_DONE;
			S_DIV_FIXQ: state_d = S_DIV_FIXR;
			S_DIV_FIXR: state_d = S_MD_DONE;
			S_MD_DONE:  if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Datapath control and next values
	always_comb begin
		add_x    = {1'b0, a};
		add_y    = {1'b0, b};
		add_sub  = 1'b0;
		acc_d    = acc_q;
		quo_d    = quo_q;
		opb_d    = opb_q;
		na_d     = na_q;
		nb_d     = nb_q;
		hi_d     = hi_q;
		lo_d     = lo_q;
		rsp_d    = rsp_q;
		rsp_load = 1'b0;
		case (state_q)
			S_EXEC: begin
				add_y   = (op_q.opcode == OP_ADDI || op_q.opcode == OP_ADDIU) ?
					{1'b0, imm_s} : {1'b0, b};
				add_sub = (op_q.opcode == OP_SUB || op_q.opcode == OP_SUBU);
				acc_d   = '0;
				quo_d   = a;
				opb_d   = b;
				na_d    = (op_q.opcode == OP_DIV || op_q.opcode == OP_MULT) && a[DATA_W-1];
				nb_d    = (op_q.opcode == OP_DIV || op_q.opcode == OP_MULT) && b[DATA_W-1];
				if (exec_done && out_free) begin
					rsp_load = 1'b1;
					rsp_d    = '{result: res_c, result_write: wr_c, overflow: ovf_c,
						hi_out: hi_q, lo_out: lo_q};
				end
			end
			S_NEG_A: begin
				add_x   = '0;
				add_y   = {1'b0, quo_q};
				add_sub = 1'b1;
				if (na_q) quo_d = add_sum[DATA_W-1:0];
			end
			S_NEG_B: begin
				add_x   = '0;
				add_y   = {1'b0, opb_q};
				add_sub = 1'b1;
				if (nb_q) opb_d = add_sum[DATA_W-1:0];
			end
			S_MUL: begin
				// Shift-add: the low bit of the multiplier selects the addend.
				add_x = {1'b0, acc_q};
				add_y = quo_q[0] ? {1'b0, opb_q} : '0;
				acc_d = add_sum[DATA_W:1];
				quo_d = {add_sum[0], quo_q[DATA_W-1:1]};
			end
			S_DIV: begin
				// Restoring step: keep the difference only when it did not borrow.
				add_x   = div_shift;
				add_y   = {1'b0, opb_q};
				add_sub = 1'b1;
				if (add_sum[DATA_W+1]) begin
					acc_d = add_sum[DATA_W-1:0];
				end else begin
					acc_d = div_shift[DATA_W-1:0];
				end
				quo_d = {quo_q[DATA_W-2:0], add_sum[DATA_W+1]};
			end
			S_MUL_FIXA: begin
				add_x   = {1'b0, acc_q};
				add_y   = {1'b0, opb_q};
				add_sub = 1'b1;
				if (na_q) acc_d = add_sum[DATA_W-1:0];
			end
			S_MUL_FIXB: begin
				add_x   = {1'b0, acc_q};
				add_y   = {1'b0, a};
				add_sub = 1'b1;
				if (nb_q) acc_d = add_sum[DATA_W-1:0];
			end
			S_DIV_FIXQ: begin
				add_x   = '0;
				add_y   = {1'b0, quo_q};
				add_sub = 1'b1;
				if (na_q ^ nb_q) quo_d = add_sum[DATA_W-1:0];
			end
			S_DIV_FIXR: begin
				add_x   = '0;
				add_y   = {1'b0, acc_q};
				add_sub = 1'b1;
				if (na_q) acc_d = add_sum[DATA_W-1:0];
			end
			S_MD_DONE: begin
				if (out_free) begin
					rsp_load = 1'b1;
					hi_d     = acc_q;
					lo_d     = quo_q;
					rsp_d    = '{result: '0, result_write: 1'b0, overflow: 1'b0,
						hi_out: acc_q, lo_out: quo_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			hi_q        <= '0;
			lo_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			hi_q    <= hi_d;
			lo_q    <= lo_d;
			if (state_q == S_MUL || state_q == S_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			op_q <= req;
		end
		acc_q <= acc_d;
		quo_q <= quo_d;
		opb_q <= opb_d;
		na_q  <= na_d;
		nb_q  <= nb_d;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	// The iteration counter only leaves zero while an iterative step is running.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_MUL && state_q != S_DIV) |-> cnt_q == '0)
		else $error("iteration counter non-zero outside mul/div");

	// HI and LO move only when a transaction's result is loaded.
	assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_load |=> ($stable(hi_q) && $stable(lo_q)))
		else $error("HI/LO changed without a result load");

	// An accepted request is always executed in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_accept |=> state_q == S_EXEC)
		else $error("accepted request did not reach execute");

	// A trapped overflow never requests a register write.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.overflow && rsp.result_write))
		else $error("overflow with write enable set");

endmodule

@@ bench/integer_alu_with_hi_lo_muldiv_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_alu_with_hi_lo_muldiv_core_tb: self-checking bench for the ALU core
// Directed corner instructions for every opcode, then a long random mix with
// bursty idling on both channels. Each request transaction is executed by a
// shadow ALU with its own HI/LO copy, and each response is checked against it.
// ----------------------------------------------------------------------------
module integer_alu_with_hi_lo_muldiv_core_tb;
	import ialu_pkg::*;

	localparam int RESET_CYCLES   = 12;
	localparam int RANDOM_ITEMS   = 1350;
	localparam int CALM_TAIL      = 150;
	localparam int DRAIN_AT       = 600;
	localparam int HOLD_AT        = 250;
	localparam int HOLD_LEN       = 150;
	localparam int TAIL_CYCLES    = 60;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [4:0] OP_FIRST_UNUSED = 5'd27;
	localparam logic [4:0] OP_LAST_UNUSED  = 5'd31;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	alu_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	alu_rsp_t rsp;

	alu_req_t    instr_q[$];
	alu_rsp_t    alu_rsp_q[$];
	logic [31:0] hi_shadow = '0;
	logic [31:0] lo_shadow = '0;

	logic req_fire  = 1'b0;
	logic hold_done = 1'b0;
	int   sent_cnt  = 0;
	int   rsp_cnt   = 0;
	int   err_cnt   = 0;
	int   total_items;
	int   send_gap  = 0;
	int   stall_cnt = 0;
	int   hold_cnt  = 0;
	int   quiet_cycles = 0;

	integer_alu_with_hi_lo_muldiv_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	// Executes one instruction against the shadow HI/LO pair.
	function automatic alu_rsp_t execute_instr(input alu_req_t r);
		alu_rsp_t    o;
		logic [31:0] a, b, imm_s, imm_z, s;
		logic [63:0] prod;
		logic [4:0]  vsa;
		a     = r.rs_value;
		b     = r.rt_value;
		imm_s = {{16{r.immediate[15]}}, r.immediate};
		imm_z = {16'h0000, r.immediate};
		vsa   = a[4:0];
		o     = '0;
		o.result_write = 1'b1;
		case (r.opcode)
		OP_ADD: begin
			s = a + b;
			o.overflow = (a[31] == b[31]) && (s[31] != a[31]);
			o.result = s;
		end
		OP_ADDI: begin
			s = a + imm_s;
			o.overflow = (a[31] == imm_s[31]) && (s[31] != a[31]);
			o.result = s;
		end
		OP_ADDIU: o.result = a + imm_s;
		OP_ADDU:  o.result = a + b;
		OP_SUB: begin
			s = a - b;
			o.overflow = (a[31] != b[31]) && (s[31] != a[31]);
			o.result = s;
		end
		OP_SUBU: o.result = a - b;
		OP_DIV: begin
			o.result_write = 1'b0;
			if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
				lo_shadow = 32'h8000_0000;
				hi_shadow = '0;
			end else if (b != '0) begin
				lo_shadow = $signed(a) / $signed(b);
				hi_shadow = $signed(a) % $signed(b);
			end
		end
		OP_DIVU: begin
			o.result_write = 1'b0;
			if (b != '0) begin
				lo_shadow = a / b;
				hi_shadow = a % b;
			end
		end
		OP_MULT: begin
			o.result_write = 1'b0;
			prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
			{hi_shadow, lo_shadow} = prod;
		end
		OP_MULTU: begin
			o.result_write = 1'b0;
			prod = {32'h0, a} * {32'h0, b};
			{hi_shadow, lo_shadow} = prod;
		end
		OP_SLL:   o.result = b << r.shift_amount;
		OP_SLLV:  o.result = b << vsa;
		OP_SRA:   o.result = $signed(b) >>> r.shift_amount;
		OP_SRAV:  o.result = $signed(b) >>> vsa;
		OP_SRL:   o.result = b >> r.shift_amount;
		OP_SRLV:  o.result = b >> vsa;
		OP_AND:   o.result = a & b;
		OP_ANDI:  o.result = a & imm_z;
		OP_NOR:   o.result = ~(a | b);
		OP_OR:    o.result = a | b;
		OP_ORI:   o.result = a | imm_z;
		OP_XOR:   o.result = a ^ b;
		OP_XORI:  o.result = a ^ imm_z;
		OP_SLT:   o.result = {31'b0, $signed(a) < $signed(b)};
		OP_SLTI:  o.result = {31'b0, $signed(a) < $signed(imm_s)};
		OP_SLTIU: o.result = {31'b0, a < imm_s};
		OP_SLTU:  o.result = {31'b0, a < b};
		default:  o.result_write = 1'b0;
		endcase
		// A trapped add or subtract writes nothing.
		if (o.overflow) begin
			o.result       = '0;
			o.result_write = 1'b0;
		end
		o.hi_out = hi_shadow;
		o.lo_out = lo_shadow;
		return o;
	endfunction

	task automatic add_item(input logic [4:0] op, input logic [31:0] a, input logic [31:0] b,
			input logic [15:0] imm, input logic [4:0] sa);
		alu_req_t r;
		r.opcode       = op;
		r.rs_value     = a;
		r.rt_value     = b;
		r.immediate    = imm;
		r.shift_amount = sa;
		instr_q.push_back(r);
	endtask

	// Operand values weighted towards the arithmetic corners.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		2: return 32'h8000_0000;
		3: return 32'h7FFF_FFFF;
		4: return $urandom_range(0, 15);
		5: return -$urandom_range(1, 16);
		default: return $urandom;
		endcase
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			err_cnt++;
		end
	endtask

	// Request driver: a transaction is held until taken, then the next one is
	// offered, possibly after a gap.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_fire) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					req_valid <= 1'b0;
				end else if (instr_q.size() == 0 ||
						(sent_cnt == DRAIN_AT && alu_rsp_q.size() != 0)) begin
					req_valid <= 1'b0;
				end else begin
					req <= instr_q.pop_front();
					req_valid <= 1'b1;
					sent_cnt <= sent_cnt + 1;
					if (instr_q.size() > CALM_TAIL && $urandom_range(0, 3) == 0)
						send_gap <= $urandom_range(1, 12);
				end
			end
		end
	end

	// Response side back-pressure, including one long hold-off that fills the
	// block and forces it to stall its request channel.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				rsp_stall <= 1'b1;
			end else if (!hold_done && rsp_cnt >= HOLD_AT) begin
				hold_done <= 1'b1;
				hold_cnt <= HOLD_LEN - 1;
				rsp_stall <= 1'b1;
			end else if (stall_cnt > 0) begin
				stall_cnt <= stall_cnt - 1;
				rsp_stall <= 1'b1;
			end else if (instr_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
				stall_cnt <= $urandom_range(0, 11);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		alu_rsp_t want;
		req_fire <= req_valid && !req_stall;
		if (arst_n) begin
			// Check before predicting: a response never belongs to a request
			// taken at the same edge.
			if (rsp_valid && !rsp_stall) begin
				rsp_cnt <= rsp_cnt + 1;
				if (alu_rsp_q.size() == 0) begin
					$display("%0t: unexpected response: expected none, got %h", $time, rsp);
					err_cnt++;
				end else begin
					want = alu_rsp_q.pop_front();
					check_field("result", want.result, rsp.result);
					check_field("result_write", {31'b0, want.result_write},
						{31'b0, rsp.result_write});
					check_field("overflow", {31'b0, want.overflow},
						{31'b0, rsp.overflow});
					check_field("hi_out", want.hi_out, rsp.hi_out);
					check_field("lo_out", want.lo_out, rsp.lo_out);
				end
			end
			if (req_valid && !req_stall)
				alu_rsp_q.push_back(execute_instr(req));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("integer_alu_with_hi_lo_muldiv_core verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		logic [4:0]  op;
		logic [31:0] a, b;

		// Overflow in both directions for ADD and SUB, upward only for ADDI.
		add_item(OP_ADD,   32'h7FFF_FFFF, 32'h0000_0001, 16'h0000, 5'd0);
		add_item(OP_ADD,   32'h8000_0000, 32'h8000_0000, 16'hFFFF, 5'd31);
		add_item(OP_ADDI,  32'h7FFF_FFFF, 32'h0,         16'h0001, 5'd0);
		add_item(OP_ADDI,  32'h0000_0005, 32'hFFFF_FFFF, 16'h8000, 5'd0);
		add_item(OP_ADDIU, 32'hFFFF_FFFF, 32'h0,         16'h7FFF, 5'd0);
		add_item(OP_ADDU,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0,    5'd0);
		add_item(OP_SUB,   32'h8000_0000, 32'h0000_0001, 16'h0,    5'd0);
		add_item(OP_SUB,   32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h0,    5'd0);
		add_item(OP_SUBU,  32'h0,         32'h0000_0001, 16'h0,    5'd0);
		add_item(OP_MULT,  32'h8000_0000, 32'h8000_0000, 16'h0,    5'd0);
		add_item(OP_MULTU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0,    5'd0);
		// Signed minimum over minus one, divide by zero, negative dividend.
		add_item(OP_DIV,   32'h8000_0000, 32'hFFFF_FFFF, 16'h0,    5'd0);
		add_item(OP_DIV,   32'h0000_1234, 32'h0,         16'h0,    5'd0);
		add_item(OP_DIV,   32'hFFFF_FFF9, 32'h0000_0002, 16'h0,    5'd0);
		add_item(OP_DIVU,  32'hFFFF_FFFF, 32'h0000_0003, 16'h0,    5'd0);
		add_item(OP_DIVU,  32'h0000_0005, 32'h0,         16'h0,    5'd0);
		add_item(OP_SLL,   32'h0,         32'h8000_0001, 16'h0,    5'd31);
		add_item(OP_SLLV,  32'hFFFF_FFE1, 32'hFFFF_FFFF, 16'h0,    5'd0);
		add_item(OP_SRA,   32'h0,         32'h8000_0000, 16'h0,    5'd31);
		add_item(OP_SRAV,  32'h0000_003F, 32'h8000_0000, 16'h0,    5'd0);
		add_item(OP_SRL,   32'h0,         32'hFFFF_FFFF, 16'h0,    5'd31);
		add_item(OP_SRLV,  32'hFFFF_FFE0, 32'hFFFF_FFFF, 16'h0,    5'd31);
		add_item(OP_AND,   32'hFFFF_FFFF, 32'hA5A5_5A5A, 16'h0,    5'd0);
		add_item(OP_ANDI,  32'hFFFF_FFFF, 32'h0,         16'hFFFF, 5'd0);
		add_item(OP_NOR,   32'h0,         32'h0,         16'h0,    5'd0);
		add_item(OP_OR,    32'h8000_0000, 32'h0000_0001, 16'h0,    5'd0);
		add_item(OP_ORI,   32'h8000_0000, 32'h0,         16'h8000, 5'd0);
		add_item(OP_XOR,   32'hFFFF_FFFF, 32'h5555_5555, 16'h0,    5'd0);
		add_item(OP_XORI,  32'hFFFF_FFFF, 32'h0,         16'hFFFF, 5'd0);
		add_item(OP_SLT,   32'h8000_0000, 32'h7FFF_FFFF, 16'h0,    5'd0);
		add_item(OP_SLTI,  32'h0,         32'h0,         16'h8000, 5'd0);
		// Sign-extended immediate makes a large unsigned bound.
		add_item(OP_SLTIU, 32'hFFFF_0000, 32'h0,         16'h8000, 5'd0);
		add_item(OP_SLTU,  32'h0,         32'hFFFF_FFFF, 16'h0,    5'd0);
		add_item(OP_LAST_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 5'd31);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			op = 5'($urandom_range(0, OP_LAST_UNUSED));
			a  = pick_word();
			b  = pick_word();
			if (op == OP_DIV && $urandom_range(0, 7) == 0) begin
				a = 32'h8000_0000;
				b = '1;
			end else if (op >= OP_FIRST_UNUSED && $urandom_range(0, 1) == 0) begin
				op = 5'($urandom_range(OP_DIV, OP_MULTU));
			end
			add_item(op, a, b, 16'(pick_word() >> 16), 5'($urandom_range(0, 31)));
		end
		total_items = instr_q.size();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (rsp_cnt < total_items) @(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0 && alu_rsp_q.size() == 0)
			$display("integer_alu_with_hi_lo_muldiv_core verification clean");
		else
			$display("integer_alu_with_hi_lo_muldiv_core verification failed");
		$finish;
	end

endmodule

@@ integer_alu_with_hi_lo_muldiv_core.f @@
rtl/ialu_pkg.sv
rtl/integer_alu_with_hi_lo_muldiv_core.sv
bench/integer_alu_with_hi_lo_muldiv_core_tb.sv
